### hw/rtl/mric_pkg.sv
// mric_pkg: shared types and constants of the mixed-radix index converter
// depends on nothing; used by every rtl file of the block
package mric_pkg;

  localparam int MAX_DIMS       = 4;
  localparam int IDX_BITS       = 8;
  localparam int SIZE_BITS      = IDX_BITS + 1;
  localparam int LIN_BITS       = 32;
  localparam int PROD_BITS      = LIN_BITS + 1;
  localparam int CNT_BITS       = 3;
  localparam int REG_IDX_BITS   = 3;
  localparam int DIV_STEPS      = 4;
  localparam int DIV_STAGES_PER = LIN_BITS / DIV_STEPS;
  localparam int DIV_STAGES     = (MAX_DIMS - 1) * DIV_STAGES_PER;
  localparam int MUL_STAGES     = 4;
  localparam int BACK_STAGES    = MUL_STAGES + DIV_STAGES;
  localparam logic [SIZE_BITS-1:0] SIZE_CAP = SIZE_BITS'(1 << IDX_BITS);

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [LIN_BITS-1:0]  lin_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef enum logic {
    OP_PACK   = 1'b0,
    OP_UNPACK = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_DIM_COUNT = 3'd0,
    REG_SIZE0     = 3'd1,
    REG_SIZE1     = 3'd2,
    REG_SIZE2     = 3'd3,
    REG_SIZE3     = 3'd4
  } reg_idx_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t                          op;
    logic                         pack_err;
    logic [MAX_DIMS-1:0][IDX_BITS-1:0]  idx;
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0] size;
    lin_t                         lin;
  } item_t;

  // working set of one back-end pipeline stage
  typedef struct packed {
    op_t                          op;
    logic                         pack_err;
    logic                         err;
    logic [MAX_DIMS-1:0][IDX_BITS-1:0]  idx;
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0] size;
    logic [MAX_DIMS-1:0][IDX_BITS-1:0]  coord;
    lin_t                         lin;
    lin_t                         acc;
    prod_t                        prod;
    lin_t                         quo;
    idx_t                         rem;
  } stg_t;

  // clamp a size register to the index range
  function automatic size_t eff_size(input size_t s);
    eff_size = (s > SIZE_CAP) ? SIZE_CAP : s;
  endfunction

endpackage

### hw/rtl/mric_front.sv
// mric_front: accepts requests, normalizes dimensions and checks pack ranges
// depends on mric_pkg
module mric_front import mric_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  operation,
  input  idx_t                  index_0,
  input  idx_t                  index_1,
  input  idx_t                  index_2,
  input  idx_t                  index_3,
  input  lin_t                  linear_in,
  input  logic [CNT_BITS-1:0]   dimension_count,
  input  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] dim_size,
  input  logic                  q_ready,
  output logic                  busy,
  output logic                  q_valid,
  output item_t                 q_item
);

  logic                valid;
  item_t               item;
  item_t               item_next;
  logic                take;
  logic [CNT_BITS-1:0] n_use;
  idx_t [MAX_DIMS-1:0] idx_in;

  assign busy    = valid && !q_ready;
  assign take    = start && !busy;
  assign q_valid = valid;
  assign q_item  = item;
  assign idx_in  = {index_3, index_2, index_1, index_0};

  // clamp dimension count and build the normalized item
  always_comb begin
    priority if (dimension_count == '0) begin
      n_use = CNT_BITS'(1);
    end else if (dimension_count > CNT_BITS'(MAX_DIMS)) begin
      n_use = CNT_BITS'(MAX_DIMS);
    end else begin
      n_use = dimension_count;
    end
    item_next.op       = op_t'(operation);
    item_next.lin      = linear_in;
    item_next.pack_err = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (CNT_BITS'(d) < n_use) begin
        item_next.size[d] = eff_size(dim_size[d]);
        item_next.idx[d]  = idx_in[d];
      end else begin
        item_next.size[d] = SIZE_BITS'(1);
        item_next.idx[d]  = '0;
      end
      if (d > 0 && {1'b0, item_next.idx[d]} >= item_next.size[d]) begin
        item_next.pack_err = 1'b1;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (q_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

### hw/rtl/mric_queue.sv
// mric_queue: two-entry queue between front and back
// depends on mric_pkg
module mric_queue import mric_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  output logic  valid,
  output item_t pop_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign ready    = (count != 2'd2);
  assign valid    = (count != 2'd0);
  assign do_push  = push && ready;
  assign do_pop   = valid;
  assign pop_item = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### hw/rtl/mric_back.sv
// mric_back: pack multiply chain, size product, range check and
// pipelined long division for unpack; depends on mric_pkg
module mric_back import mric_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  done,
  output lin_t  linear_out,
  output idx_t  coord_0,
  output idx_t  coord_1,
  output idx_t  coord_2,
  output idx_t  coord_3,
  output logic  status
);

  stg_t st  [BACK_STAGES];
  logic vld [BACK_STAGES];
  stg_t s0_next;
  stg_t s1_next;
  stg_t s2_next;
  stg_t s3_next;
  logic [LIN_BITS+SIZE_BITS-1:0]  mul_acc1;
  logic [LIN_BITS+SIZE_BITS-1:0]  mul_acc2;
  logic [PROD_BITS+SIZE_BITS-1:0] mul_prod1;
  logic [PROD_BITS+SIZE_BITS-1:0] mul_prod2;
  stg_t last;

  // stage 0: first fold of pack, first product of sizes
  always_comb begin
    s0_next          = '0;
    s0_next.op       = in_item.op;
    s0_next.pack_err = in_item.pack_err;
    s0_next.idx      = in_item.idx;
    s0_next.size     = in_item.size;
    s0_next.lin      = in_item.lin;
    s0_next.acc      = LIN_BITS'(in_item.idx[0]) * LIN_BITS'(in_item.size[1])
                     + LIN_BITS'(in_item.idx[1]);
    s0_next.prod     = PROD_BITS'(in_item.size[0]) * PROD_BITS'(in_item.size[1]);
  end

  // stage 1: fold third dimension
  always_comb begin
    s1_next      = st[0];
    mul_acc1     = (LIN_BITS+SIZE_BITS)'(st[0].acc) * (LIN_BITS+SIZE_BITS)'(st[0].size[2]);
    mul_prod1    = (PROD_BITS+SIZE_BITS)'(st[0].prod)
                 * (PROD_BITS+SIZE_BITS)'(st[0].size[2]);
    s1_next.acc  = mul_acc1[LIN_BITS-1:0] + LIN_BITS'(st[0].idx[2]);
    s1_next.prod = mul_prod1[PROD_BITS-1:0];
  end

  // stage 2: fold fourth dimension
  always_comb begin
    s2_next      = st[1];
    mul_acc2     = (LIN_BITS+SIZE_BITS)'(st[1].acc) * (LIN_BITS+SIZE_BITS)'(st[1].size[3]);
    mul_prod2    = (PROD_BITS+SIZE_BITS)'(st[1].prod)
                 * (PROD_BITS+SIZE_BITS)'(st[1].size[3]);
    s2_next.acc  = mul_acc2[LIN_BITS-1:0] + LIN_BITS'(st[1].idx[3]);
    s2_next.prod = mul_prod2[PROD_BITS-1:0];
  end

  // stage 3: error decision and divider setup
  always_comb begin
    s3_next     = st[2];
    s3_next.quo = st[2].lin;
    s3_next.rem = '0;
    unique case (st[2].op)
      OP_PACK:   s3_next.err = st[2].pack_err;
      OP_UNPACK: s3_next.err = ({1'b0, st[2].lin} >= st[2].prod);
      default:   s3_next.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    st[0] <= s0_next;
    st[1] <= s1_next;
    st[2] <= s2_next;
    st[3] <= s3_next;
  end

  // valid chain through all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BACK_STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int i = 1; i < BACK_STAGES; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // divider stages: innermost dimension first, four quotient bits each
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int DIM = MAX_DIMS - 1 - k / DIV_STAGES_PER;
    localparam bit LAST = (k % DIV_STAGES_PER) == (DIV_STAGES_PER - 1);
    stg_t            nx;
    logic [SIZE_BITS-1:0] t;
    idx_t            r;
    lin_t            qq;

    always_comb begin
      nx = st[MUL_STAGES-1+k];
      r  = nx.rem;
      qq = nx.quo;
      t  = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        t  = {r, qq[LIN_BITS-1]};
        qq = {qq[LIN_BITS-2:0], 1'b0};
        if (t >= nx.size[DIM]) begin
          t     = t - nx.size[DIM];
          qq[0] = 1'b1;
        end
        r = t[IDX_BITS-1:0];
      end
      nx.quo = qq;
      nx.rem = r;
      if (LAST) begin
        nx.coord[DIM] = r;
        nx.rem        = '0;
      end
    end

    always_ff @(posedge clk) begin
      st[MUL_STAGES+k] <= nx;
    end
  end

  assign last = st[BACK_STAGES-1];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[BACK_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    status     <= last.err;
    linear_out <= '0;
    coord_0    <= '0;
    coord_1    <= '0;
    coord_2    <= '0;
    coord_3    <= '0;
    if (!last.err) begin
      if (last.op == OP_PACK) begin
        linear_out <= last.acc;
      end else begin
        coord_0 <= last.quo[IDX_BITS-1:0];
        coord_1 <= last.coord[1];
        coord_2 <= last.coord[2];
        coord_3 <= last.coord[3];
      end
    end
  end

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status |-> linear_out == '0 && coord_0 == '0 && coord_1 == '0
      && coord_2 == '0 && coord_3 == '0)
    else $error("error result carries nonzero data");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    vld[BACK_STAGES-1] |=> done)
    else $error("last stage beat lost at result register");

  a_pack_no_coord: assert property (@(posedge clk) disable iff (rst)
    vld[BACK_STAGES-1] && last.op == OP_PACK |=> coord_1 == '0 && coord_2 == '0
      && coord_3 == '0)
    else $error("pack result carries coordinates");
`endif

endmodule

### hw/rtl/mixed_radix_index_converter_top.sv
// A start passes the front register, queue, back-end stages and result register to done.
// Throughput: one request per cycle, set by the fully pipelined divider and multiplier chain.
// The receiver cannot stall; busy stays low in steady operation.
// Reset (rst, synchronous, active high) empties the pipeline, sets the count and sizes to 1.
// top level: config registers, front, queue and back; depends on mric_pkg and the mric_* modules
module mixed_radix_index_converter_top import mric_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  idx_t                    index_0,
  input  idx_t                    index_1,
  input  idx_t                    index_2,
  input  idx_t                    index_3,
  input  lin_t                    linear_in,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]    cfg_data,
  output logic                    done,
  output lin_t                    linear_out,
  output idx_t                    coord_0,
  output idx_t                    coord_1,
  output idx_t                    coord_2,
  output idx_t                    coord_3,
  output logic                    status
);

  logic [CNT_BITS-1:0]                dimension_count;
  logic [MAX_DIMS-1:0][SIZE_BITS-1:0] dim_size;
  logic                               fq_valid;
  item_t                              fq_item;
  logic                               fq_ready;
  logic                               qb_valid;
  item_t                              qb_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension_count <= CNT_BITS'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        dim_size[d] <= SIZE_BITS'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM_COUNT: dimension_count <= cfg_data[CNT_BITS-1:0];
        REG_SIZE0:     dim_size[0]     <= cfg_data;
        REG_SIZE1:     dim_size[1]     <= cfg_data;
        REG_SIZE2:     dim_size[2]     <= cfg_data;
        REG_SIZE3:     dim_size[3]     <= cfg_data;
        default: ;
      endcase
    end
  end

  mric_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .operation       (operation),
    .index_0         (index_0),
    .index_1         (index_1),
    .index_2         (index_2),
    .index_3         (index_3),
    .linear_in       (linear_in),
    .dimension_count (dimension_count),
    .dim_size        (dim_size),
    .q_ready         (fq_ready),
    .busy            (busy),
    .q_valid         (fq_valid),
    .q_item          (fq_item)
  );

  mric_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fq_valid),
    .push_item (fq_item),
    .ready     (fq_ready),
    .valid     (qb_valid),
    .pop_item  (qb_item)
  );

  mric_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qb_valid),
    .in_item    (qb_item),
    .done       (done),
    .linear_out (linear_out),
    .coord_0    (coord_0),
    .coord_1    (coord_1),
    .coord_2    (coord_2),
    .coord_3    (coord_3),
    .status     (status)
  );

endmodule
